@@ design/multi_motor_step_scheduler_macros.svh @@
// Assertion helpers for the step scheduler
`ifndef MULTI_MOTOR_STEP_SCHEDULER_MACROS_SVH
`define MULTI_MOTOR_STEP_SCHEDULER_MACROS_SVH

// same-cycle implication
`define MMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mms_pkg.sv @@
package mms_pkg;

  localparam int CNT_W      = 16;
  localparam int DLY_W      = 16;
  localparam int NUM_DELAYS = 4;
  localparam int OUT_BITS   = 4;
  localparam int MAX_MOTORS = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [DLY_W-1:0] ELA_MAX = {DLY_W{1'b1}};

  typedef logic [DLY_W-1:0] delay_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [1:0]              motor_index;
    logic signed [CNT_W-1:0] step_count;
  } item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] step_pulses;
    logic [OUT_BITS-1:0] step_directions;
    logic                moving;
    logic                done_res;
  } result_t;

endpackage

@@ design/mms_channels.sv @@
interface mms_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic [1:0]                       motor_index;
  logic signed [mms_pkg::CNT_W-1:0] step_count;

  modport source(output valid, output mode, output motor_index, output step_count,
                 input ready);
  modport sink(input valid, input mode, input motor_index, input step_count,
               output ready);
endinterface

interface mms_out_if;
  logic                           valid;
  logic                           ready;
  logic [mms_pkg::OUT_BITS-1:0]   step_pulses;
  logic [mms_pkg::OUT_BITS-1:0]   step_directions;
  logic                           moving;
  logic                           done_res;

  modport source(output valid, output step_pulses, output step_directions,
                 output moving, output done_res, input ready);
  modport sink(input valid, input step_pulses, input step_directions,
               input moving, input done_res, output ready);
endinterface

@@ design/mms_cfg_regs.sv @@
module mms_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            we,
  input  logic [mms_pkg::CFG_IDX_W-1:0]   index,
  input  logic [mms_pkg::DLY_W-1:0]       data,
  output mms_pkg::delay_t                 delays [mms_pkg::NUM_DELAYS]
);

  mms_pkg::delay_t delay_r [mms_pkg::NUM_DELAYS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mms_pkg::NUM_DELAYS; k++) begin
        delay_r[k] <= mms_pkg::DLY_W'(1);
      end
    end else if (we) begin
      for (int k = 0; k < mms_pkg::NUM_DELAYS; k++) begin
        if (int'(index) == k) begin
          delay_r[k] <= data;
        end
      end
    end
  end

  assign delays = delay_r;

endmodule

@@ design/mms_step_core.sv @@
module mms_step_core #(
  parameter int MOTORS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  mms_pkg::item_t   item,
  input  mms_pkg::delay_t  delays [mms_pkg::NUM_DELAYS],
  output mms_pkg::result_t res
);

  logic signed [mms_pkg::CNT_W-1:0] rem_r   [MOTORS];
  logic signed [mms_pkg::CNT_W-1:0] rem_nxt [MOTORS];
  logic [mms_pkg::DLY_W-1:0]        ela_r   [MOTORS];
  logic [mms_pkg::DLY_W-1:0]        ela_nxt [MOTORS];
  logic                             act_r;
  logic                             act_nxt;

  mms_pkg::delay_t                  dly_full [mms_pkg::MAX_MOTORS];
  logic [mms_pkg::MAX_MOTORS-1:0]   pulse_v;
  logic [mms_pkg::MAX_MOTORS-1:0]   dir_v;
  logic                             done;
  logic                             any_left;
  logic [mms_pkg::DLY_W-1:0]        ela_inc;

  always_comb begin
    for (int k = 0; k < mms_pkg::MAX_MOTORS; k++) begin
      dly_full[k] = mms_pkg::DLY_W'(1);
    end
    for (int k = 0; k < mms_pkg::NUM_DELAYS; k++) begin
      dly_full[k] = delays[k];
    end
  end

  always_comb begin
    for (int m = 0; m < MOTORS; m++) begin
      rem_nxt[m] = rem_r[m];
      ela_nxt[m] = ela_r[m];
    end
    act_nxt  = act_r;
    pulse_v  = '0;
    dir_v    = '0;
    done     = 1'b0;
    any_left = 1'b0;
    ela_inc  = '0;
    case (item.mode)
      mms_pkg::MODE_LOAD: begin
        for (int m = 0; m < MOTORS; m++) begin
          if (int'(item.motor_index) == m) begin
            rem_nxt[m] = item.step_count;
          end
        end
      end
      mms_pkg::MODE_START: begin
        for (int m = 0; m < MOTORS; m++) begin
          ela_nxt[m] = '0;
          if (rem_r[m] != '0) begin
            any_left = 1'b1;
          end
        end
        if (any_left) begin
          act_nxt = 1'b1;
        end
      end
      mms_pkg::MODE_TICK: begin
        if (act_r) begin
          for (int m = 0; m < MOTORS; m++) begin
            ela_inc = (ela_r[m] == mms_pkg::ELA_MAX) ? ela_r[m]
                                                      : ela_r[m] + mms_pkg::DLY_W'(1);
            ela_nxt[m] = ela_inc;
            if (ela_inc >= dly_full[m] && rem_r[m] != '0) begin
              pulse_v[m] = 1'b1;
              ela_nxt[m] = '0;
              if (rem_r[m] > 0) begin
                rem_nxt[m] = rem_r[m] - mms_pkg::CNT_W'(1);
              end else begin
                rem_nxt[m] = rem_r[m] + mms_pkg::CNT_W'(1);
                dir_v[m]   = 1'b1;
              end
            end
            if (rem_nxt[m] != '0) begin
              any_left = 1'b1;
            end
          end
          if (!any_left) begin
            act_nxt = 1'b0;
            done    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < MOTORS; m++) begin
        rem_r[m] <= '0;
        ela_r[m] <= '0;
      end
      act_r <= 1'b0;
    end else if (en) begin
      rem_r <= rem_nxt;
      ela_r <= ela_nxt;
      act_r <= act_nxt;
    end
  end

  assign res.step_pulses     = pulse_v[mms_pkg::OUT_BITS-1:0];
  assign res.step_directions = dir_v[mms_pkg::OUT_BITS-1:0];
  assign res.moving          = act_nxt;
  assign res.done_res        = done;

endmodule

@@ design/multi_motor_step_scheduler.sv @@
// Step pulse scheduler for up to four stepper motors (four delay registers).
// Requests arrive on in_ch (valid/ready): load a motor's signed step count,
// start a move, or apply one timer tick. Every request yields exactly one
// result on out_ch: step pulse and direction bits for motors 0..3, the moving
// flag, and done_res on the tick that leaves no steps remaining.
// Step delays are written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. A request
// passes through the input register, then the result register; one request
// per cycle while out_ch is not stalled. All motors update together in the
// single logic stage between the two registers, so the motor count does not
// slow a tick. A stalled receiver holds the result register; the input
// register still takes one more request, then in_ch.ready drops until out_ch
// moves on. Reset (rst_n low, synchronous) clears counts, elapsed counters
// and the move flag, empties both registers and sets every delay to one tick.
`include "multi_motor_step_scheduler_macros.svh"

module multi_motor_step_scheduler #(
  parameter int MOTORS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mms_in_if.sink                        in_ch,
  mms_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mms_pkg::DLY_W-1:0]     cfg_data
);

  mms_pkg::item_t   s1_r;
  logic             s1_v_r;
  mms_pkg::result_t out_r;
  logic             out_v_r;
  mms_pkg::result_t res;
  mms_pkg::delay_t  delays [mms_pkg::NUM_DELAYS];
  logic             out_free;
  logic             adv;
  logic             in_acc;

  assign out_free    = !out_v_r || out_ch.ready;
  assign adv         = s1_v_r && out_free;
  assign in_ch.ready = !s1_v_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  mms_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .we     (cfg_we),
    .index  (cfg_index),
    .data   (cfg_data),
    .delays (delays)
  );

  mms_step_core #(.MOTORS(MOTORS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item   (s1_r),
    .delays (delays),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.mode        <= in_ch.mode;
      s1_r.motor_index <= in_ch.motor_index;
      s1_r.step_count  <= in_ch.step_count;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.step_pulses     = out_r.step_pulses;
  assign out_ch.step_directions = out_r.step_directions;
  assign out_ch.moving          = out_r.moving;
  assign out_ch.done_res        = out_r.done_res;

  `MMS_ASSERT_IMP(a_done_ends_move, out_v_r && out_r.done_res, !out_r.moving, "done while moving")
  `MMS_ASSERT_IMP(a_dir_needs_pulse, out_v_r, (out_r.step_directions & ~out_r.step_pulses) == '0, "direction without pulse")
  `MMS_ASSERT_NXT(a_no_pulse_off_tick, adv && s1_r.mode != mms_pkg::MODE_TICK, out_r.step_pulses == '0 && !out_r.done_res, "pulse on non-tick request")
  `MMS_ASSERT_IMP(a_no_overrun, s1_v_r && !out_free, !in_ch.ready, "input taken while pipeline full")

endmodule

@@ bench/tb_multi_motor_step_scheduler.sv @@
module tb_multi_motor_step_scheduler;

  localparam int          MOTORS      = 4;
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          NUM_ROWS    = 32;
  localparam int          RANDOM_REQS = 1950;
  localparam int          PHASES      = 8;
  localparam logic [1:0]  MODE_NONE   = 2'd3;

  localparam logic [mms_pkg::CFG_IDX_W-1:0] REG_DELAY0 = 2'd0;
  localparam logic [mms_pkg::CFG_IDX_W-1:0] REG_DELAY1 = 2'd1;
  localparam logic [mms_pkg::CFG_IDX_W-1:0] REG_DELAY2 = 2'd2;
  localparam logic [mms_pkg::CFG_IDX_W-1:0] REG_DELAY3 = 2'd3;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;
  typedef enum {CHK_PREDICT, CHK_IDLE, CHK_MOVING} chk_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  mode;
    logic [1:0]  idx;
    logic [15:0] val;
    int          reps;
    chk_t        chk;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mms_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mms_pkg::DLY_W-1:0]     cfg_data;

  mms_in_if  in_if ();
  mms_out_if out_if ();

  multi_motor_step_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scheduler state as the testbench sees it
  mms_pkg::delay_t                  step_delay  [MOTORS];
  logic signed [mms_pkg::CNT_W-1:0] steps_left  [MOTORS];
  logic [mms_pkg::DLY_W-1:0]        ticks_since [MOTORS];
  bit                               move_on;

  mms_pkg::result_t pending_results [$];
  int               mismatches;
  int               requests_sent;
  int               cycles;
  bit               calm;
  row_t             plan [NUM_ROWS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic row_t row(row_kind_t kind, logic [1:0] mode, logic [1:0] idx,
                               logic [15:0] val, int reps, chk_t chk);
    row_t r;
    r.kind = kind;
    r.mode = mode;
    r.idx  = idx;
    r.val  = val;
    r.reps = reps;
    r.chk  = chk;
    return r;
  endfunction

  function automatic mms_pkg::result_t advance_scheduler(logic [1:0] mode, logic [1:0] idx,
      logic signed [mms_pkg::CNT_W-1:0] count);
    mms_pkg::result_t r;
    bit               any;
    r = '0;
    any = 1'b0;
    case (mode)
      mms_pkg::MODE_LOAD: begin
        steps_left[idx] = count;
      end
      mms_pkg::MODE_START: begin
        for (int m = 0; m < MOTORS; m++) begin
          ticks_since[m] = '0;
          if (steps_left[m] != 0) any = 1'b1;
        end
        if (any) move_on = 1'b1;
      end
      mms_pkg::MODE_TICK: begin
        if (move_on) begin
          for (int m = 0; m < MOTORS; m++) begin
            if (ticks_since[m] != mms_pkg::ELA_MAX) ticks_since[m] = ticks_since[m] + 1'b1;
            if (ticks_since[m] >= step_delay[m] && steps_left[m] != 0) begin
              r.step_pulses[m] = 1'b1;
              if (steps_left[m] > 0) begin
                steps_left[m] = steps_left[m] - 16'sd1;
              end else begin
                steps_left[m] = steps_left[m] + 16'sd1;
                r.step_directions[m] = 1'b1;
              end
              ticks_since[m] = '0;
            end
            if (steps_left[m] != 0) any = 1'b1;
          end
          if (!any) begin
            move_on = 1'b0;
            r.done_res = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.moving = move_on;
    return r;
  endfunction

  function automatic logic signed [mms_pkg::CNT_W-1:0] pick_count();
    logic signed [mms_pkg::CNT_W-1:0] c;
    if ($urandom_range(99) < 12) return 16'($urandom);
    c = 16'($urandom_range(0, 12));
    return c - 16'sd6;
  endfunction

  function automatic mms_pkg::delay_t pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 5) return mms_pkg::ELA_MAX;
    if (r < 8) return 16'($urandom);
    return 16'($urandom_range(1, 4));
  endfunction

  task automatic send_request(logic [1:0] mode, logic [1:0] idx,
                              logic signed [mms_pkg::CNT_W-1:0] count, chk_t chk);
    mms_pkg::result_t want;
    bit               ignored;
    while (!calm && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= mode;
    in_if.motor_index <= idx;
    in_if.step_count  <= count;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    ignored = (mode == MODE_NONE) || (mode == mms_pkg::MODE_TICK && !move_on);
    want = advance_scheduler(mode, idx, count);
    if (chk == CHK_IDLE) begin
      want = '0;
    end else if (chk == CHK_MOVING) begin
      want = '0;
      want.moving = 1'b1;
    end
    pending_results.insert(pending_results.size(), want);
    if (!ignored) requests_sent++;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(logic [mms_pkg::CFG_IDX_W-1:0] idx, mms_pkg::delay_t value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    step_delay[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_burst();
    int r;
    int ticks;
    repeat ($urandom_range(1, 4))
      send_request(mms_pkg::MODE_LOAD, 2'($urandom_range(0, 3)), pick_count(), CHK_PREDICT);
    if ($urandom_range(9) != 0)
      send_request(mms_pkg::MODE_START, 2'($urandom), 16'($urandom), CHK_PREDICT);
    ticks = $urandom_range(1, 40);
    for (int t = 0; t < ticks; t++) begin
      r = $urandom_range(99);
      if (r < 5)
        send_request(mms_pkg::MODE_LOAD, 2'($urandom_range(0, 3)), pick_count(), CHK_PREDICT);
      else if (r < 8)
        send_request(mms_pkg::MODE_START, 2'($urandom), 16'($urandom), CHK_PREDICT);
      else if (r < 11)
        send_request(MODE_NONE, 2'($urandom), 16'($urandom), CHK_PREDICT);
      else
        send_request(mms_pkg::MODE_TICK, 2'($urandom), 16'($urandom), CHK_PREDICT);
      if (!move_on && $urandom_range(1) == 0) break;
    end
  endtask

  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    mms_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("step_pulses", want.step_pulses, out_if.step_pulses);
        check_field("step_directions", want.step_directions, out_if.step_directions);
        check_field("moving", 4'(want.moving), 4'(out_if.moving));
        check_field("done_res", 4'(want.done_res), 4'(out_if.done_res));
      end
    end
    out_if.ready <= calm || ($urandom_range(99) >= 13);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.mode        <= mms_pkg::MODE_LOAD;
    in_if.motor_index <= '0;
    in_if.step_count  <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_DELAY0;
    cfg_data          <= '0;
    mismatches    = 0;
    requests_sent = 0;
    cycles        = 0;
    calm          = 1'b0;
    move_on       = 1'b0;
    for (int m = 0; m < MOTORS; m++) begin
      step_delay[m]  = 16'd1;
      steps_left[m]  = '0;
      ticks_since[m] = '0;
    end

    plan = '{
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_START, 2'd0, 16'h0000, 1, CHK_IDLE),
      row(ROW_REQ, MODE_NONE,           2'd3, 16'hFFFF, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd0, 16'h7FFF, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd1, 16'h8000, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd0, 16'h0003, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd1, 16'hFFFE, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd2, 16'h0001, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd3, 16'hFFFF, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_START, 2'd0, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 4, CHK_PREDICT),
      row(ROW_CFG, mms_pkg::MODE_LOAD,  REG_DELAY0, 16'h0000, 1, CHK_PREDICT),
      row(ROW_CFG, mms_pkg::MODE_LOAD,  REG_DELAY1, 16'hFFFF, 1, CHK_PREDICT),
      row(ROW_CFG, mms_pkg::MODE_LOAD,  REG_DELAY2, 16'h0002, 1, CHK_PREDICT),
      row(ROW_CFG, mms_pkg::MODE_LOAD,  REG_DELAY3, 16'h0003, 1, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd0, 16'h0002, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd1, 16'h8000, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_START, 2'd0, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 3, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd2, 16'h0002, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_START, 2'd0, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 5, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd1, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 2, CHK_PREDICT),
      // slow motors hold the move open across a run of ticks
      row(ROW_CFG, mms_pkg::MODE_LOAD,  REG_DELAY0, 16'hFFFF, 1, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd0, 16'h0002, 1, CHK_IDLE),
      row(ROW_REQ, mms_pkg::MODE_START, 2'd0, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 40, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd1, 16'h0001, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 1, CHK_PREDICT),
      row(ROW_REQ, mms_pkg::MODE_LOAD,  2'd0, 16'h0000, 1, CHK_MOVING),
      row(ROW_REQ, mms_pkg::MODE_TICK,  2'd0, 16'h0000, 2, CHK_PREDICT)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_delay(plan[i].idx, plan[i].val);
      else
        repeat (plan[i].reps)
          send_request(plan[i].mode, plan[i].idx, plan[i].val, plan[i].chk);
    end

    requests_sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      calm = (phase == 3);
      for (int m = 0; m < MOTORS; m++) write_delay(2'(m), pick_delay());
      while (requests_sent < RANDOM_REQS * (phase + 1) / PHASES) run_burst();
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
